@@ sv/front_panel_display_ram_controller_defines.svh @@
// Assertion macros for the front-panel display controller.
// Included by the top-level module, which carries the concurrent assertions; no dependencies.
`ifndef FRONT_PANEL_DISPLAY_RAM_CONTROLLER_DEFINES_SVH
`define FRONT_PANEL_DISPLAY_RAM_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpd assertion failed");

// next-cycle implication, disabled in reset
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpd assertion failed");

`endif

@@ sv/fpd_pkg.sv @@
// Package for the front-panel display controller: opcodes, states, structs,
// display tables and digit helpers. No dependencies.
`timescale 1ns / 1ps

package fpd_pkg;

   localparam int IMAGE_BYTES = 14;
   localparam int ADDR_W      = $clog2(IMAGE_BYTES);
   localparam int FONT_W      = 35;
   localparam int KEYMAP_W    = 25;
   localparam int SEG_W       = 7;
   localparam int DIGITS      = 6;
   localparam int RING_SEGS   = 8;
   localparam int ICON_COUNT  = 9;
   localparam int BUTTONS     = 5;
   localparam int KEY_BITS    = 20;
   localparam int KEY_NUM_W   = 5;
   localparam int SCAN_BYTES  = 5;

   localparam logic [7:0] CMD_DATA_WRITE = 8'h44;
   localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
   localparam logic [7:0] CMD_BRIGHTNESS = 8'h88;
   localparam logic [7:0] COLON_BIT      = 8'd64;
   localparam logic [7:0] DIGIT_MASK     = 8'h02 | 8'h80 | 8'h04 | 8'h08 | 8'h10 | 8'h20;
   localparam logic [3:0] BRIGHT_MAX     = 4'd7;
   localparam logic [3:0] PROGRESS_MAX   = 4'd8;
   localparam logic [3:0] RING_POS_LAST  = 4'd7;
   localparam logic [3:0] ICON_LAST      = 4'd8;
   localparam logic [4:0] KEY_NUM_LAST   = 5'd19;

   localparam logic [ADDR_W-1:0] COLON_ADDR [2] = '{4'd2, 4'd4};

   // segment position masks: left tens/ones, center tens/ones, right tens/ones
   localparam logic [7:0] DIGIT_POS [DIGITS] = '{8'd2, 8'd128, 8'd4, 8'd8, 8'd16, 8'd32};

   localparam logic [ADDR_W-1:0] RING_ADDR [RING_SEGS] =
      '{4'd3, 4'd11, 4'd13, 4'd7, 4'd5, 4'd9, 4'd13, 4'd1};
   localparam logic [7:0] RING_BIT [RING_SEGS] =
      '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd1};

   localparam logic [ADDR_W-1:0] ICON_ADDR [ICON_COUNT] =
      '{4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd6, 4'd8};
   localparam logic [7:0] ICON_BIT [ICON_COUNT] =
      '{8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd64, 8'd64, 8'd64};

   typedef enum logic [3:0] {
      OP_CLEAR         = 4'd0,
      OP_VALUES        = 4'd1,
      OP_COLON         = 4'd2,
      OP_ICON          = 4'd3,
      OP_DISC_SINGLE   = 4'd4,
      OP_DISC_PROGRESS = 4'd5,
      OP_DISC_RAW      = 4'd6,
      OP_UPDATE        = 4'd7,
      OP_BRIGHTNESS    = 4'd8,
      OP_KEYS          = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      CSR_FONT_LOW  = 2'd0,
      CSR_FONT_HIGH = 2'd1,
      CSR_KEY_MAP   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDIT,
      ST_HEADER,
      ST_FRAMES,
      ST_SINGLE
   } state_type;

   typedef struct packed {
      op_type                      op;
      logic                        flag;
      logic [3:0]                  idx;
      logic [RING_SEGS-1:0]        ring;
      logic [DIGITS-1:0][SEG_W-1:0] seg;
   } edit_cmd_type;

   typedef struct packed {
      logic                kind;
      logic [7:0]          command;
      logic [7:0]          data;
      logic                has_data;
      logic                last;
      logic [KEY_BITS-1:0] keys;
      logic [BUTTONS-1:0]  buttons;
      logic [2:0]          first;
   } rsp_type;

   // floor(v/10) by reciprocal, exact for 7-bit v
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [14:0] p;
      p = 15'(v) * 15'd205;
      return p[14:11];
   endfunction

   function automatic logic [3:0] tens_digit(input logic [6:0] v);
      logic [3:0] q;
      q = div10(v);
      return (q >= 4'd10) ? q - 4'd10 : q;
   endfunction

   function automatic logic [3:0] ones_digit(input logic [6:0] v);
      logic [6:0] r;
      r = v - 7'(div10(v)) * 7'd10;
      return r[3:0];
   endfunction

   function automatic logic [SEG_W-1:0] font_seg(input logic [FONT_W-1:0] low,
                                                 input logic [FONT_W-1:0] high,
                                                 input logic [3:0] d);
      if (d < 4'd5) return low[SEG_W*d +: SEG_W];
      return high[SEG_W*(d - 4'd5) +: SEG_W];
   endfunction

endpackage

@@ sv/fpd_byte_unit.sv @@
// Shared byte update unit: computes the new value of one display image byte
// for an edit command. Depends on fpd_pkg.
`timescale 1ns / 1ps

module fpd_byte_unit (
   input  fpd_pkg::edit_cmd_type      cmd,
   input  logic [fpd_pkg::ADDR_W-1:0] addr,
   input  logic [7:0]                 old_byte,
   output logic [7:0]                 new_byte
);

   logic [2:0] seg_row;
   logic [7:0] set_mask;
   logic [7:0] clr_mask;

   assign seg_row = addr[3:1];

   always_comb begin
      new_byte = old_byte;
      set_mask = '0;
      clr_mask = '0;
      unique case (cmd.op)
         fpd_pkg::OP_CLEAR: begin
            new_byte = '0;
         end
         fpd_pkg::OP_VALUES: begin
            if (!addr[0]) begin
               for (int j = 0; j < fpd_pkg::DIGITS; j++) begin
                  if (cmd.seg[j][seg_row]) set_mask = set_mask | fpd_pkg::DIGIT_POS[j];
               end
               new_byte = (old_byte & ~fpd_pkg::DIGIT_MASK) | set_mask;
            end
         end
         fpd_pkg::OP_COLON: begin
            if (addr == fpd_pkg::COLON_ADDR[0] || addr == fpd_pkg::COLON_ADDR[1]) begin
               new_byte = cmd.flag ? (old_byte | fpd_pkg::COLON_BIT)
                                   : (old_byte & ~fpd_pkg::COLON_BIT);
            end
         end
         fpd_pkg::OP_ICON: begin
            if (cmd.idx <= fpd_pkg::ICON_LAST && fpd_pkg::ICON_ADDR[cmd.idx] == addr) begin
               new_byte = cmd.flag ? (old_byte | fpd_pkg::ICON_BIT[cmd.idx])
                                   : (old_byte & ~fpd_pkg::ICON_BIT[cmd.idx]);
            end
         end
         fpd_pkg::OP_DISC_SINGLE, fpd_pkg::OP_DISC_PROGRESS, fpd_pkg::OP_DISC_RAW: begin
            for (int i = 0; i < fpd_pkg::RING_SEGS; i++) begin
               if (fpd_pkg::RING_ADDR[i] == addr) begin
                  clr_mask = clr_mask | fpd_pkg::RING_BIT[i];
                  if (cmd.ring[i]) set_mask = set_mask | fpd_pkg::RING_BIT[i];
               end
            end
            new_byte = (old_byte & ~clr_mask) | set_mask;
         end
         default: ;
      endcase
   end

endmodule

@@ sv/front_panel_display_ram_controller.sv @@
// Front-panel display controller top level: command sequencer, 14-byte image,
// key decode and output word register. Depends on fpd_pkg, fpd_byte_unit and
// front_panel_display_ram_controller_defines.svh.
//
// Usage:
//   req_*  : one command word per handshake; req_ready is high only when idle.
//   rsp_*  : result words (serial frames or one key result), held in an output
//            register until rsp_ready takes them.
//   csr_*  : font and key map writes, always ready, index 0..2.
// Timing:
//   Edit commands (clear, values, colon, icon, disc) walk the image one byte
//   per cycle through the shared byte unit, then return to idle.
//   Update emits 15 frames, one per cycle while rsp_ready stays high; the
//   header word is loaded into the output register from the header state
//   that follows acceptance. Brightness and keys each give one result word.
//   A stalled receiver holds the sequencer in place; nothing is dropped.
// Reset: clears the image, loads the default font and key map and empties the
//   output register.
`timescale 1ns / 1ps
`include "front_panel_display_ram_controller_defines.svh"

module front_panel_display_ram_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [6:0]  req_left_value,
   input  logic [6:0]  req_center_value,
   input  logic [6:0]  req_right_value,
   input  logic [2:0]  req_blank_groups,
   input  logic        req_flag_on,
   input  logic [3:0]  req_item_index,
   input  logic [7:0]  req_ring_mask,
   input  logic [39:0] req_key_scan_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_frame_command,
   output logic [7:0]  rsp_frame_data,
   output logic        rsp_frame_has_data,
   output logic        rsp_frame_last,
   output logic [19:0] rsp_key_vector,
   output logic [4:0]  rsp_button_bits,
   output logic [2:0]  rsp_first_button,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [34:0] csr_data
);

   localparam logic [fpd_pkg::ADDR_W-1:0] ADDR_LAST = fpd_pkg::ADDR_W'(fpd_pkg::IMAGE_BYTES - 1);

   fpd_pkg::state_type    state_ff, state_in;
   logic [fpd_pkg::ADDR_W-1:0] cnt_ff, cnt_in;
   fpd_pkg::edit_cmd_type cmd_ff, cmd_in, accept_cmd;
   fpd_pkg::rsp_type      pend_ff, pend_in, single_rsp;
   fpd_pkg::rsp_type      rsp_ff, rsp_next;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   logic [7:0]            image_ff [fpd_pkg::IMAGE_BYTES];
   logic                  img_we;
   logic [7:0]            rd_byte, new_byte;

   logic [fpd_pkg::FONT_W-1:0]   font_low_ff, font_high_ff;
   logic [fpd_pkg::KEYMAP_W-1:0] key_map_ff;

   fpd_pkg::op_type       req_op;
   logic [6:0]            group_value [3];
   logic                  req_fire, slot_free;
   logic [fpd_pkg::KEY_BITS-1:0] keys;
   logic [fpd_pkg::BUTTONS-1:0]  buttons;
   logic [2:0]            first;
   logic [7:0]            scan_byte;
   logic [4:0]            key_num;
   logic [3:0]            level;

   assign req_op    = fpd_pkg::op_type'(req_opcode);
   assign req_ready = (state_ff == fpd_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign group_value[0] = req_left_value;
   assign group_value[1] = req_center_value;
   assign group_value[2] = req_right_value;

   function automatic logic [7:0] ring_of(input fpd_pkg::op_type op, input logic [3:0] idx,
                                          input logic [7:0] raw);
      logic [3:0] n;
      n = (idx > fpd_pkg::PROGRESS_MAX) ? fpd_pkg::PROGRESS_MAX : idx;
      if (op == fpd_pkg::OP_DISC_SINGLE)
         return (idx <= fpd_pkg::RING_POS_LAST) ? (8'd1 << idx[2:0]) : 8'd0;
      if (op == fpd_pkg::OP_DISC_PROGRESS)
         return 8'((9'd1 << n) - 9'd1);
      return raw;
   endfunction

   // command latched for the edit sweep
   always_comb begin
      accept_cmd.op   = req_op;
      accept_cmd.flag = req_flag_on;
      accept_cmd.idx  = req_item_index;
      accept_cmd.ring = ring_of(req_op, req_item_index, req_ring_mask);
      for (int g = 0; g < 3; g++) begin
         accept_cmd.seg[2*g]   = req_blank_groups[g] ? '0 :
            fpd_pkg::font_seg(font_low_ff, font_high_ff, fpd_pkg::tens_digit(group_value[g]));
         accept_cmd.seg[2*g+1] = req_blank_groups[g] ? '0 :
            fpd_pkg::font_seg(font_low_ff, font_high_ff, fpd_pkg::ones_digit(group_value[g]));
      end
   end

   // key decode and brightness word
   always_comb begin
      keys    = '0;
      buttons = '0;
      first   = '0;
      for (int p = 0; p < fpd_pkg::SCAN_BYTES; p++) begin
         scan_byte     = req_key_scan_bytes[8*p +: 8];
         keys[4*p]     = scan_byte[0];
         keys[4*p + 1] = scan_byte[1];
         keys[4*p + 2] = scan_byte[3];
         keys[4*p + 3] = scan_byte[4];
      end
      for (int i = 0; i < fpd_pkg::BUTTONS; i++) begin
         key_num = key_map_ff[fpd_pkg::KEY_NUM_W*i +: fpd_pkg::KEY_NUM_W];
         if (key_num <= fpd_pkg::KEY_NUM_LAST) buttons[i] = keys[key_num];
      end
      for (int i = fpd_pkg::BUTTONS - 1; i >= 0; i--) begin
         if (buttons[i]) first = 3'(i + 1);
      end
      level = (req_item_index > fpd_pkg::BRIGHT_MAX) ? fpd_pkg::BRIGHT_MAX : req_item_index;
      single_rsp = '0;
      if (req_op == fpd_pkg::OP_KEYS) begin
         single_rsp.kind    = 1'b1;
         single_rsp.keys    = keys;
         single_rsp.buttons = buttons;
         single_rsp.first   = first;
      end else begin
         single_rsp.command = fpd_pkg::CMD_BRIGHTNESS | {4'd0, level};
         single_rsp.last    = 1'b1;
      end
   end

   assign rd_byte = image_ff[cnt_ff];

   fpd_byte_unit u_byte_unit (
      .cmd      (cmd_ff),
      .addr     (cnt_ff),
      .old_byte (rd_byte),
      .new_byte (new_byte)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd_in   = cmd_ff;
      pend_in  = pend_ff;
      img_we   = 1'b0;
      rsp_load = 1'b0;
      rsp_next = '0;
      unique case (state_ff)
         fpd_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in = accept_cmd;
               cnt_in = '0;
               unique case (req_op) inside
                  [fpd_pkg::OP_CLEAR:fpd_pkg::OP_DISC_RAW]: state_in = fpd_pkg::ST_EDIT;
                  fpd_pkg::OP_UPDATE: state_in = fpd_pkg::ST_HEADER;
                  fpd_pkg::OP_BRIGHTNESS, fpd_pkg::OP_KEYS: begin
                     pend_in  = single_rsp;
                     state_in = fpd_pkg::ST_SINGLE;
                  end
                  default: ;
               endcase
            end
         end
         fpd_pkg::ST_EDIT: begin
            img_we = 1'b1;
            if (cnt_ff == ADDR_LAST) state_in = fpd_pkg::ST_IDLE;
            else cnt_in = cnt_ff + 1'b1;
         end
         fpd_pkg::ST_HEADER: begin
            if (slot_free) begin
               rsp_load         = 1'b1;
               rsp_next.command = fpd_pkg::CMD_DATA_WRITE;
               state_in         = fpd_pkg::ST_FRAMES;
            end
         end
         fpd_pkg::ST_FRAMES: begin
            if (slot_free) begin
               rsp_load          = 1'b1;
               rsp_next.command  = fpd_pkg::CMD_ADDR_BASE + 8'(cnt_ff);
               rsp_next.data     = rd_byte;
               rsp_next.has_data = 1'b1;
               rsp_next.last     = (cnt_ff == ADDR_LAST);
               if (cnt_ff == ADDR_LAST) state_in = fpd_pkg::ST_IDLE;
               else cnt_in = cnt_ff + 1'b1;
            end
         end
         fpd_pkg::ST_SINGLE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_next = pend_ff;
               state_in = fpd_pkg::ST_IDLE;
            end
         end
         default: state_in = fpd_pkg::ST_IDLE;
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpd_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      pend_ff <= pend_in;
      if (rsp_load) rsp_ff <= rsp_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fpd_pkg::IMAGE_BYTES; i++) image_ff[i] <= '0;
      end else if (img_we) begin
         image_ff[cnt_ff] <= new_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_low_ff  <= 35'd27547583295;
         font_high_ff <= 35'd30062804717;
         key_map_ff   <= 25'd33554431;
      end else if (csr_valid && csr_ready) begin
         unique case (fpd_pkg::csr_index_type'(csr_index))
            fpd_pkg::CSR_FONT_LOW:  font_low_ff  <= csr_data;
            fpd_pkg::CSR_FONT_HIGH: font_high_ff <= csr_data;
            fpd_pkg::CSR_KEY_MAP:   key_map_ff   <= csr_data[fpd_pkg::KEYMAP_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_ff.kind;
   assign rsp_frame_command  = rsp_ff.command;
   assign rsp_frame_data     = rsp_ff.data;
   assign rsp_frame_has_data = rsp_ff.has_data;
   assign rsp_frame_last     = rsp_ff.last;
   assign rsp_key_vector     = rsp_ff.keys;
   assign rsp_button_bits    = rsp_ff.buttons;
   assign rsp_first_button   = rsp_ff.first;

   `FPD_ASSERT_NEXT(a_update_header, clock, reset,
      req_fire && req_op == fpd_pkg::OP_UPDATE, state_ff == fpd_pkg::ST_HEADER)
   `FPD_ASSERT_IMPL(a_last_is_frame, clock, reset,
      rsp_valid_ff && rsp_ff.last, !rsp_ff.kind)
   `FPD_ASSERT_NEXT(a_edit_quiet, clock, reset,
      state_ff == fpd_pkg::ST_EDIT && !rsp_valid_ff, !rsp_valid_ff)
   `FPD_ASSERT_NEXT(a_frames_end, clock, reset,
      state_ff == fpd_pkg::ST_FRAMES && rsp_load && rsp_next.last,
      state_ff == fpd_pkg::ST_IDLE && rsp_valid_ff)

endmodule
